[hw/rtl/idtpw_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idtpw_pkg
// Shared types and constants of the device table page walker.
// ----------------------------------------------------------------------------
package idtpw_pkg;

  localparam int unsigned IdBitsDefault = 16;

  typedef enum logic [1:0] {
    REQ_TRANSLATE = 2'd0,
    REQ_RESPONSE  = 2'd1,
    REQ_RESUME    = 2'd2,
    REQ_UNUSED    = 2'd3
  } req_type_e;

  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_DTE_ROOT = 3'd1,
    PH_DTE      = 3'd2,
    PH_ATP      = 3'd3,
    PH_PTE      = 3'd4
  } walk_phase_e;

  typedef enum logic [2:0] {
    FC_NONE     = 3'd0,
    FC_DTE_RSVD = 3'd1,
    FC_PTE_INV  = 3'd2,
    FC_PTE_RSVD = 3'd3,
    FC_MISALIGN = 3'd4,
    FC_NO_READ  = 3'd5,
    FC_NO_WRITE = 3'd6
  } fault_code_e;

  typedef enum logic [1:0] {
    REG_TABLE_BASE = 2'd0,
    REG_XLATE_EN   = 2'd1,
    REG_IRQ_EN     = 2'd2,
    REG_ID_SPLIT   = 2'd3
  } reg_index_e;

  localparam logic [3:0] ModeBare = 4'd0;
  localparam logic [3:0] ModeSv32 = 4'd1;
  localparam logic [3:0] ModeSv39 = 4'd8;
  localparam logic [3:0] ModeSv48 = 4'd9;
  localparam logic [3:0] ModeSv57 = 4'd10;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [15:0] requester_id;
    logic [63:0] io_address;
    logic [1:0]  access_flags;
    logic [63:0] read_word;
  } in_item_t;

  typedef struct packed {
    logic        out_kind;
    logic [63:0] read_address;
    logic [63:0] phys_address;
    logic        granted;
    logic        fault_flag;
    logic [2:0]  fault_code;
    logic [15:0] fault_requester;
    logic [63:0] fault_address;
    logic        irq_level;
  } out_item_t;

  // classified item from front to back
  typedef struct packed {
    req_type_e   kind;
    logic [15:0] requester_id;
    logic [63:0] io_address;
    logic [1:0]  access_flags;
    logic [63:0] read_word;
  } cmd_t;

  // low n bits set, n up to 63
  function automatic logic [63:0] low_mask(input logic [5:0] n);
    low_mask = ~(64'hffff_ffff_ffff_ffff << n);
  endfunction

endpackage

[hw/rtl/iommu_device_table_page_walker_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iommu_device_table_page_walker_unit
// IOMMU device table lookup and stage-one page table walker.
// ----------------------------------------------------------------------------
// an item is held in a front queue entry, then in the walker's result register
// throughput: one item per cycle unless the result stage is stalled; the pace
// of a walk is set by memory responses
// reset: asynchronous; walk idle, fault record clear, registers zero
module iommu_device_table_page_walker_unit #(
  parameter int unsigned IdBits = idtpw_pkg::IdBitsDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  idtpw_pkg::in_item_t  in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output idtpw_pkg::out_item_t out_item_o,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [4:0]           paddr,
  input  logic [63:0]          pwdata,
  output logic [63:0]          prdata,
  output logic                 pready
);
  import idtpw_pkg::*;

  logic        cmd_valid, cmd_ready;
  cmd_t        cmd;
  logic [63:0] base_q;
  logic        xen_q, ien_q;
  logic [4:0]  split_q;
  logic        wr_en;
  reg_index_e  ridx;

  assign pready = 1'b1;
  assign ridx   = reg_index_e'(paddr[4:3]);
  assign wr_en  = psel && penable && pwrite && pready;

  // register file, 8-byte spacing
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= '0; xen_q <= 1'b0; ien_q <= 1'b0; split_q <= '0;
    end else if (wr_en) begin
      case (ridx)
        REG_TABLE_BASE: base_q  <= pwdata;
        REG_XLATE_EN:   xen_q   <= pwdata[0];
        REG_IRQ_EN:     ien_q   <= pwdata[0];
        REG_ID_SPLIT:   split_q <= pwdata[4:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (ridx)
      REG_TABLE_BASE: prdata = base_q;
      REG_XLATE_EN:   prdata = {63'd0, xen_q};
      REG_IRQ_EN:     prdata = {63'd0, ien_q};
      REG_ID_SPLIT:   prdata = {59'd0, split_q};
      default:        prdata = '0;
    endcase
  end

  idtpw_front #(.Depth(2)) u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_item_i,
    .cmd_valid_o(cmd_valid), .cmd_ready_i(cmd_ready), .cmd_o(cmd)
  );

  idtpw_walker #(.IdBits(IdBits)) u_walker (
    .clk_i, .rst_ni, .cmd_valid_i(cmd_valid), .cmd_ready_o(cmd_ready), .cmd_i(cmd),
    .table_base_i(base_q), .xlate_en_i(xen_q), .irq_en_i(ien_q), .id_split_i(split_q),
    .out_valid_o, .out_ready_i, .out_item_o
  );

  // result stage holds while stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");
  // a granted result never carries a read request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.granted |-> out_item_o.out_kind)
    else $error("grant on read request");
  // irq only with a recorded fault
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.irq_level |-> out_item_o.fault_flag)
    else $error("irq without fault");

endmodule

[hw/rtl/idtpw_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idtpw_front
// Accepts items, drops unknown types and queues the rest for the walker.
// ----------------------------------------------------------------------------
module idtpw_front #(
  parameter int unsigned Depth = 2
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  idtpw_pkg::in_item_t in_item_i,
  output logic              cmd_valid_o,
  input  logic              cmd_ready_i,
  output idtpw_pkg::cmd_t   cmd_o
);
  import idtpw_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;

  cmd_t              fifo_q [Depth];
  logic [PtrW-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [PtrW:0]     cnt_q, cnt_d;
  logic              push, pop, keep;
  cmd_t              cmd_new;

  // classify incoming item
  always_comb begin
    cmd_new.kind         = req_type_e'(in_item_i.req_type);
    cmd_new.requester_id = in_item_i.requester_id;
    cmd_new.io_address   = in_item_i.io_address;
    cmd_new.access_flags = in_item_i.access_flags;
    cmd_new.read_word    = in_item_i.read_word;
    keep = (cmd_new.kind != REQ_UNUSED);
  end

  assign in_ready_o  = (cnt_q != (PtrW+1)'(Depth));
  assign push        = in_valid_i && in_ready_o && keep;
  assign cmd_valid_o = (cnt_q != '0);
  assign pop         = cmd_valid_o && cmd_ready_i;
  assign cmd_o       = fifo_q[rd_q];

  // pointers
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push) begin
      wr_d = (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop) begin
      rd_d = (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_q] <= cmd_new;
    end
  end

endmodule

[hw/rtl/idtpw_walker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idtpw_walker
// Device table and page table walk state machine with fault record and
// a registered result stage.
// ----------------------------------------------------------------------------
module idtpw_walker #(
  parameter int unsigned IdBits = idtpw_pkg::IdBitsDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cmd_valid_i,
  output logic                cmd_ready_o,
  input  idtpw_pkg::cmd_t     cmd_i,
  input  logic [63:0]         table_base_i,
  input  logic                xlate_en_i,
  input  logic                irq_en_i,
  input  logic [4:0]          id_split_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output idtpw_pkg::out_item_t out_item_o
);
  import idtpw_pkg::*;

  localparam int unsigned IdW = (IdBits < 16) ? IdBits : 16;

  walk_phase_e phase_q, phase_d;
  logic [15:0] pid_q, pid_d;
  logic [63:0] paddr_q, paddr_d;
  logic [1:0]  pacc_q, pacc_d;
  logic [63:0] tptr_q, tptr_d;
  logic [3:0]  mode_q, mode_d;
  logic [2:0]  level_q, level_d;
  logic        fv_q, fv_d;
  logic [2:0]  fc_q, fc_d;
  logic [15:0] fid_q, fid_d;
  logic [63:0] fa_q, fa_d;
  logic        irq_q, irq_d;
  logic        ov_q, ov_d;
  out_item_t   out_q, out_d;

  logic        take, emit, is_fault, is_read, is_done;
  logic [2:0]  fcode;
  logic [63:0] raddr, phys;
  logic [4:0]  split;
  logic [15:0] id_in;
  logic [63:0] w;
  logic [3:0]  amode;
  logic [63:0] pte, ppn;
  logic [2:0]  rwx;
  logic [5:0]  shift_cur;
  logic [2:0]  lvl_next;
  logic [63:0] tptr_next;

  assign cmd_ready_o = !ov_q || out_ready_i;
  assign take        = cmd_valid_i && cmd_ready_o;
  assign w           = cmd_i.read_word;
  assign split       = (id_split_i > 5'(IdW)) ? 5'(IdW) : id_split_i;
  assign id_in       = cmd_i.requester_id & 16'(low_mask(6'(IdW)));

  // level shift from the pte index width
  function automatic logic [5:0] lvl_shift(input logic [3:0] m, input logic [2:0] l);
    lvl_shift = (m == ModeSv32) ? 6'(l) * 6'd10 : 6'(l) * 6'd9;
  endfunction

  function automatic logic [63:0] pte_word_addr(input logic [3:0] m, input logic [2:0] l,
                                                input logic [63:0] base,
                                                input logic [63:0] va);
    logic [63:0] idx;
    idx = (va >> (6'd12 + lvl_shift(m, l))) & low_mask((m == ModeSv32) ? 6'd10 : 6'd9);
    pte_word_addr = base + ((m == ModeSv32) ? (idx << 2) : (idx << 3));
  endfunction

  // walk step
  always_comb begin
    phase_d = phase_q; pid_d = pid_q; paddr_d = paddr_q; pacc_d = pacc_q;
    tptr_d = tptr_q; mode_d = mode_q; level_d = level_q;
    fv_d = fv_q; fc_d = fc_q; fid_d = fid_q; fa_d = fa_q; irq_d = irq_q;
    emit = 1'b0; is_fault = 1'b0; is_read = 1'b0; is_done = 1'b0;
    fcode = FC_NONE; raddr = '0; phys = '0;
    amode = w[63:60];
    pte = (mode_q == ModeSv32) ? {32'd0, w[31:0]} : w;
    ppn = {10'd0, pte[63:10]} & 64'h0000_0fff_ffff_ffff;
    rwx = pte[3:1];
    shift_cur = lvl_shift(mode_q, level_q);
    lvl_next = level_q - 3'd1;
    tptr_next = ppn << 12;
    if (take) begin
      case (cmd_i.kind)
        REQ_RESUME: begin
          fv_d = 1'b0; fc_d = FC_NONE; fid_d = '0; irq_d = 1'b0;
        end
        REQ_TRANSLATE: begin
          if (phase_q == PH_IDLE) begin
            pid_d = id_in; paddr_d = cmd_i.io_address; pacc_d = cmd_i.access_flags;
            if (!xlate_en_i) begin
              is_done = 1'b1; phys = cmd_i.io_address;
            end else if (split != '0) begin
              is_read = 1'b1; phase_d = PH_DTE_ROOT;
              raddr = table_base_i + {45'd0, (id_in >> split), 3'd0};
            end else begin
              is_read = 1'b1; phase_d = PH_DTE;
              raddr = table_base_i + {45'd0, id_in, 3'd0};
            end
          end
        end
        REQ_RESPONSE: begin
          case (phase_q)
            PH_DTE_ROOT: begin
              if (w[2:0] != 3'd0) begin
                is_fault = 1'b1; fcode = FC_DTE_RSVD;
              end else begin
                is_read = 1'b1; phase_d = PH_DTE;
                raddr = w + {45'd0, (pid_q & 16'(low_mask(6'(split)))), 3'd0};
              end
            end
            PH_DTE: begin
              if (!w[0] || !w[2]) begin
                is_done = 1'b1; phys = paddr_q;
              end else begin
                is_read = 1'b1; phase_d = PH_ATP; raddr = {w[63:3], 3'd0};
              end
            end
            PH_ATP: begin
              if (amode == ModeBare) begin
                is_done = 1'b1; phys = paddr_q;
              end else if (amode == ModeSv32 || amode == ModeSv39 ||
                           amode == ModeSv48 || amode == ModeSv57) begin
                mode_d = amode;
                level_d = (amode == ModeSv32) ? 3'd1 : 3'(amode - 4'd6);
                tptr_d = {8'd0, w[43:0], 12'd0};
                is_read = 1'b1; phase_d = PH_PTE;
                raddr = pte_word_addr(amode, level_d, tptr_d, paddr_q);
              end else begin
                is_fault = 1'b1; fcode = FC_PTE_INV;
              end
            end
            PH_PTE: begin
              if (!pte[0]) begin
                is_fault = 1'b1; fcode = FC_PTE_INV;
              end else if (rwx == 3'd0) begin
                if (level_q == 3'd0) begin
                  is_fault = 1'b1; fcode = FC_PTE_INV;
                end else begin
                  tptr_d = tptr_next; level_d = lvl_next;
                  is_read = 1'b1; phase_d = PH_PTE;
                  raddr = pte_word_addr(mode_q, lvl_next, tptr_next, paddr_q);
                end
              end else if (rwx == 3'd2 || rwx == 3'd6) begin
                is_fault = 1'b1; fcode = FC_PTE_RSVD;
              end else if ((ppn & low_mask(shift_cur)) != '0) begin
                is_fault = 1'b1; fcode = FC_MISALIGN;
              end else if (pacc_q[0] && !rwx[0]) begin
                is_fault = 1'b1; fcode = FC_NO_READ;
              end else if (pacc_q[1] && !rwx[1]) begin
                is_fault = 1'b1; fcode = FC_NO_WRITE;
              end else begin
                is_done = 1'b1;
                phys = ((ppn | ((paddr_q >> 12) & low_mask(shift_cur))) << 12) |
                       {52'd0, paddr_q[11:0]};
              end
            end
            default: begin
            end
          endcase
        end
        default: begin
        end
      endcase
    end
    if (is_fault) begin
      fv_d = 1'b1; fc_d = fcode; fid_d = pid_q; fa_d = paddr_q;
      if (irq_en_i) irq_d = 1'b1;
      phys = paddr_q;
    end
    if (is_fault || is_done) phase_d = PH_IDLE;
    emit = is_fault || is_done || is_read;
    out_d.out_kind        = !is_read;
    out_d.read_address    = raddr;
    out_d.phys_address    = phys;
    out_d.granted         = is_done;
    out_d.fault_flag      = fv_d;
    out_d.fault_code      = fc_d;
    out_d.fault_requester = fid_d;
    out_d.fault_address  = fa_d;
    out_d.irq_level       = irq_d;
    ov_d = emit ? 1'b1 : (out_ready_i ? 1'b0 : ov_q);
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE; pid_q <= '0; paddr_q <= '0; pacc_q <= '0;
      tptr_q <= '0; mode_q <= '0; level_q <= '0;
      fv_q <= 1'b0; fc_q <= FC_NONE; fid_q <= '0; fa_q <= '0; irq_q <= 1'b0;
      ov_q <= 1'b0;
    end else begin
      phase_q <= phase_d; pid_q <= pid_d; paddr_q <= paddr_d; pacc_q <= pacc_d;
      tptr_q <= tptr_d; mode_q <= mode_d; level_q <= level_d;
      fv_q <= fv_d; fc_q <= fc_d; fid_q <= fid_d; fa_q <= fa_d; irq_q <= irq_d;
      ov_q <= ov_d;
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = ov_q;
  assign out_item_o  = out_q;

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Testbench of the device table page walker. A local walker model tracks the
// walk state, the fault record and the registers, and works out the expected
// result of every accepted item. Directed tests cover pass-through, device
// table cases, every walk mode and each fault kind. Random walks with noise
// follow under several idle and stall mixes.
// ----------------------------------------------------------------------------
module tb;
  import idtpw_pkg::*;

  localparam int unsigned RandItems = 1350;
  localparam int unsigned CycleLimit = 400000;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_ready_o;
  in_item_t   in_item_i = '0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  out_item_t  out_item_o;
  logic       psel = 1'b0;
  logic       penable = 1'b0;
  logic       pwrite = 1'b0;
  logic [4:0] paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic       pready;

  iommu_device_table_page_walker_unit dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_item_i,
    .out_valid_o, .out_ready_i, .out_item_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  // clock
  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // walker model: registers
  logic [63:0] m_base;
  logic        m_xlate_en, m_irq_en;
  logic [4:0]  m_split;
  // walker model: walk state and fault record
  walk_phase_e m_phase;
  logic [15:0] m_id;
  logic [63:0] m_addr;
  logic [1:0]  m_access;
  logic [63:0] m_table;
  logic [3:0]  m_mode;
  logic [2:0]  m_level;
  logic        m_fault_valid;
  fault_code_e m_fault_code;
  logic [15:0] m_fault_id;
  logic [63:0] m_fault_addr;
  logic        m_irq;

  out_item_t walker_results_q[$];
  int unsigned fails, items_sent, results_checked, faults_seen, cycles;
  int unsigned send_idle_pct, stall_pct;

  function automatic logic [63:0] ones_below(int unsigned n);
    return (n >= 64) ? '1 : ((64'd1 << n) - 64'd1);
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic int unsigned split_now();
    return (m_split > 16) ? 16 : m_split;
  endfunction

  function automatic out_item_t make_result(logic kind, logic [63:0] raddr,
                                            logic [63:0] phys, logic grant);
    out_item_t o;
    o.out_kind = kind;
    o.read_address = raddr;
    o.phys_address = phys;
    o.granted = grant;
    o.fault_flag = m_fault_valid;
    o.fault_code = m_fault_code;
    o.fault_requester = m_fault_id;
    o.fault_address = m_fault_addr;
    o.irq_level = m_irq;
    return o;
  endfunction

  function automatic out_item_t fetch_word(walk_phase_e ph, logic [63:0] a);
    m_phase = ph;
    return make_result(1'b0, a, '0, 1'b0);
  endfunction

  function automatic out_item_t grant_walk(logic [63:0] phys);
    m_phase = PH_IDLE;
    return make_result(1'b1, '0, phys, 1'b1);
  endfunction

  function automatic out_item_t fault_walk(fault_code_e c);
    m_fault_valid = 1'b1;
    m_fault_code = c;
    m_fault_id = m_id;
    m_fault_addr = m_addr;
    if (m_irq_en) m_irq = 1'b1;
    faults_seen++;
    m_phase = PH_IDLE;
    return make_result(1'b1, '0, m_addr, 1'b0);
  endfunction

  function automatic out_item_t fetch_pte();
    int unsigned bits, sh;
    logic [63:0] idx;
    bits = (m_mode == ModeSv32) ? 10 : 9;
    sh = m_level * bits;
    idx = (m_addr >> (12 + sh)) & ones_below(bits);
    return fetch_word(PH_PTE, m_table + idx * ((m_mode == ModeSv32) ? 4 : 8));
  endfunction

  function automatic out_item_t take_atp(logic [63:0] w);
    int unsigned levels;
    case (w[63:60])
      ModeBare: return grant_walk(m_addr);
      ModeSv32: levels = 2;
      ModeSv39: levels = 3;
      ModeSv48: levels = 4;
      ModeSv57: levels = 5;
      default:  return fault_walk(FC_PTE_INV);
    endcase
    m_mode = w[63:60];
    m_level = 3'(levels - 1);
    m_table = {20'd0, w[43:0]} << 12;
    return fetch_pte();
  endfunction

  function automatic out_item_t take_pte(logic [63:0] w);
    int unsigned sh;
    logic [63:0] pte, ppn, vpn;
    logic [2:0] rwx;
    sh = m_level * ((m_mode == ModeSv32) ? 10 : 9);
    pte = (m_mode == ModeSv32) ? {32'd0, w[31:0]} : w;
    ppn = (pte & 64'h003f_ffff_ffff_ffff) >> 10;
    rwx = pte[3:1];
    if (!pte[0]) return fault_walk(FC_PTE_INV);
    if (rwx == 3'b000) begin
      if (m_level == 0) return fault_walk(FC_PTE_INV);
      m_table = ppn << 12;
      m_level--;
      return fetch_pte();
    end
    if (rwx == 3'b010 || rwx == 3'b110) return fault_walk(FC_PTE_RSVD);
    if ((ppn & ones_below(sh)) != 0) return fault_walk(FC_MISALIGN);
    if (m_access[0] && !rwx[0]) return fault_walk(FC_NO_READ);
    if (m_access[1] && !rwx[1]) return fault_walk(FC_NO_WRITE);
    vpn = m_addr >> 12;
    return grant_walk(((ppn | (vpn & ones_below(sh))) << 12) | (m_addr & 64'hfff));
  endfunction

  // advance the walker model by one item; 1 when a result is due
  function automatic bit predict_walker_step(input in_item_t it, output out_item_t o);
    logic [63:0] w;
    w = it.read_word;
    o = '0;
    case (it.req_type)
      REQ_RESUME: begin
        m_fault_valid = 1'b0;
        m_fault_code = FC_NONE;
        m_fault_id = '0;
        m_irq = 1'b0;
        return 1'b0;
      end
      REQ_TRANSLATE: begin
        if (m_phase != PH_IDLE) return 1'b0;
        m_id = it.requester_id;
        m_addr = it.io_address;
        m_access = it.access_flags;
        if (!m_xlate_en) o = grant_walk(m_addr);
        else if (split_now() != 0)
          o = fetch_word(PH_DTE_ROOT, m_base + (({48'd0, m_id} >> split_now()) << 3));
        else o = fetch_word(PH_DTE, m_base + ({48'd0, m_id} << 3));
        return 1'b1;
      end
      REQ_RESPONSE: begin
        case (m_phase)
          PH_DTE_ROOT: begin
            if (w[2:0] != 0) o = fault_walk(FC_DTE_RSVD);
            else o = fetch_word(PH_DTE,
                                w + (({48'd0, m_id} & ones_below(split_now())) << 3));
          end
          PH_DTE: begin
            if (!w[0] || !w[2]) o = grant_walk(m_addr);
            else o = fetch_word(PH_ATP, {w[63:3], 3'b000});
          end
          PH_ATP: o = take_atp(w);
          PH_PTE: o = take_pte(w);
          default: return 1'b0;
        endcase
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  // send one item and record its expected result at acceptance
  task automatic send_item(input in_item_t it);
    out_item_t o;
    while ($urandom_range(99) < send_idle_pct) @(negedge clk_i);
    in_valid_i = 1'b1;
    in_item_i = it;
    do @(posedge clk_i); while (!in_ready_o);
    if (predict_walker_step(it, o)) walker_results_q.push_back(o);
    items_sent++;
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  task automatic send_translate(logic [15:0] id, logic [63:0] a, logic [1:0] acc);
    in_item_t it;
    it = '0;
    it.req_type = REQ_TRANSLATE;
    it.requester_id = id;
    it.io_address = a;
    it.access_flags = acc;
    it.read_word = rand64();
    send_item(it);
  endtask

  task automatic send_word(logic [63:0] w);
    in_item_t it;
    it = {REQ_RESPONSE, 16'($urandom), rand64(), 2'($urandom), w};
    send_item(it);
  endtask

  task automatic send_other(req_type_e k);
    in_item_t it;
    it = {k, 16'($urandom), rand64(), 2'($urandom), rand64()};
    send_item(it);
  endtask

  // wait for all results, then for the block to settle
  task automatic drain();
    wait (walker_results_q.size() == 0);
    repeat (6) @(posedge clk_i);
  endtask

  // register write: setup cycle, then access cycle
  task automatic write_reg(reg_index_e idx, logic [63:0] v);
    drain();
    @(negedge clk_i);
    psel = 1'b1;
    pwrite = 1'b1;
    penable = 1'b0;
    paddr = {idx, 3'b000};
    pwdata = v;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    case (idx)
      REG_TABLE_BASE: m_base = v;
      REG_XLATE_EN:   m_xlate_en = v[0];
      REG_IRQ_EN:     m_irq_en = v[0];
      REG_ID_SPLIT:   m_split = v[4:0];
      default: ;
    endcase
  endtask

  // translate, device table entry and atp, so the walk stands at its first pte
  task automatic start_walk(logic [3:0] mode, logic [1:0] acc, logic [63:0] a);
    send_translate(16'h1234, a, acc);
    send_word(64'h0000_0000_8000_2005);
    send_word({mode, 16'd0, 44'h0_0000_0123});
  endtask

  // receiver stalls
  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= stall_pct);
  end

  // result check against the oldest expectation
  always @(posedge clk_i) begin
    out_item_t e, g;
    if (rst_ni && out_valid_o && out_ready_i) begin
      g = out_item_o;
      if (walker_results_q.size() == 0) begin
        $error("unexpected result item %h", g);
        fails++;
      end else begin
        e = walker_results_q.pop_front();
        results_checked++;
        if (g.out_kind !== e.out_kind) begin
          $error("out_kind exp %h got %h", e.out_kind, g.out_kind); fails++;
        end
        if (g.read_address !== e.read_address) begin
          $error("read_address exp %h got %h", e.read_address, g.read_address); fails++;
        end
        if (g.phys_address !== e.phys_address) begin
          $error("phys_address exp %h got %h", e.phys_address, g.phys_address); fails++;
        end
        if (g.granted !== e.granted) begin
          $error("granted exp %h got %h", e.granted, g.granted); fails++;
        end
        if (g.fault_flag !== e.fault_flag) begin
          $error("fault_flag exp %h got %h", e.fault_flag, g.fault_flag); fails++;
        end
        if (g.fault_code !== e.fault_code) begin
          $error("fault_code exp %h got %h", e.fault_code, g.fault_code); fails++;
        end
        if (g.fault_requester !== e.fault_requester) begin
          $error("fault_requester exp %h got %h", e.fault_requester, g.fault_requester);
          fails++;
        end
        if (g.fault_address !== e.fault_address) begin
          $error("fault_address exp %h got %h", e.fault_address, g.fault_address); fails++;
        end
        if (g.irq_level !== e.irq_level) begin
          $error("irq_level exp %h got %h", e.irq_level, g.irq_level); fails++;
        end
      end
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("status: fail");
      $finish;
    end
  end

  // translation off: addresses pass through; a stray response and an unknown type are sent too
  task automatic test_bypass();
    send_translate(16'hffff, '1, 2'b11);
    send_translate(16'h0000, '0, 2'b00);
    send_other(REQ_RESPONSE);
    send_other(REQ_UNUSED);
  endtask

  // device table: reserved root, invalid entry, stage one off
  task automatic test_device_table();
    write_reg(REG_XLATE_EN, 64'd1);
    write_reg(REG_IRQ_EN, 64'd1);
    write_reg(REG_ID_SPLIT, 64'd16);
    write_reg(REG_TABLE_BASE, '1);
    send_translate(16'hffff, 64'h0000_0000_dead_b000, 2'b01);
    send_word(64'h0000_0000_0001_0003);
    send_translate(16'h0001, 64'h10, 2'b01);
    send_other(REQ_RESUME);
    send_word(64'h0000_0000_0001_0000);
    send_word(64'h0000_0000_0000_0004);
    write_reg(REG_ID_SPLIT, 64'd0);
    write_reg(REG_TABLE_BASE, 64'h8000_0000);
    send_translate(16'h00ab, 64'h20, 2'b10);
    send_word(64'hffff_ffff_ffff_fff1);
  endtask

  // every mode, bare, and an unknown mode
  task automatic test_modes();
    logic [3:0] modes[5];
    modes = '{ModeSv32, ModeSv39, ModeSv48, ModeSv57, ModeBare};
    write_reg(REG_IRQ_EN, 64'd0);
    foreach (modes[i]) begin
      start_walk(modes[i], 2'b11, rand64());
      while (m_phase == PH_PTE)
        send_word((m_level == 0) ? 64'h0000_0000_0004_00cf : 64'h0000_0000_0000_4401);
    end
    start_walk(4'd5, 2'b01, 64'h1000);
  endtask

  // each pte fault kind
  task automatic test_pte_faults();
    logic [63:0] words[6];
    logic [1:0]  acc[6];
    words = '{64'h0, 64'h5, 64'hd, 64'h0000_0000_0004_040f, 64'h3, 64'h9};
    acc   = '{2'b01, 2'b01, 2'b01, 2'b01, 2'b10, 2'b01};
    foreach (words[i]) begin
      start_walk(ModeSv39, acc[i], rand64());
      send_word(words[i]);
    end
    // non-leaf at the last level
    start_walk(ModeSv39, 2'b01, '0);
    repeat (3) send_word(64'h401);
    send_other(REQ_RESUME);
  endtask

  // random walks with mostly well-formed tables and some noise
  task automatic random_walk();
    logic [63:0] w;
    int unsigned sh;
    send_translate(16'($urandom), rand64(), 2'($urandom));
    while (m_phase != PH_IDLE) begin
      if ($urandom_range(99) < 6)
        send_other($urandom_range(1) ? REQ_RESUME : REQ_TRANSLATE);
      if ($urandom_range(99) < 2) send_other(REQ_UNUSED);
      w = rand64();
      case (m_phase)
        PH_DTE_ROOT: if ($urandom_range(99) < 90) w[2:0] = 3'b000;
        PH_DTE: if ($urandom_range(99) < 85) begin
          w[0] = 1'b1;
          w[2] = 1'b1;
        end
        PH_ATP: begin
          case ($urandom_range(9))
            0: w[63:60] = ModeBare;
            1, 2: w[63:60] = ModeSv32;
            3, 4: w[63:60] = ModeSv39;
            5, 6: w[63:60] = ModeSv48;
            7, 8: w[63:60] = ModeSv57;
            default: ;
          endcase
        end
        PH_PTE: begin
          w[0] = ($urandom_range(99) < 95);
          if (m_level != 0 && $urandom_range(99) < 60) w[3:1] = 3'b000;
          else if ($urandom_range(99) < 75) begin
            w[3:1] = {1'($urandom), 1'($urandom), 1'b1};
            if (w[3:1] == 3'b000) w[1] = 1'b1;
            sh = m_level * ((m_mode == ModeSv32) ? 10 : 9);
            if ($urandom_range(99) < 70) w = w & ~(ones_below(sh) << 10);
          end
        end
        default: ;
      endcase
      send_word(w);
    end
    if ($urandom_range(99) < 5) send_other(REQ_RESPONSE);
    if ($urandom_range(99) < 15) send_other(REQ_RESUME);
  endtask

  task automatic random_config();
    write_reg(REG_XLATE_EN, {63'd0, $urandom_range(99) < 92});
    write_reg(REG_IRQ_EN, 64'($urandom_range(1)));
    case ($urandom_range(3))
      0: write_reg(REG_ID_SPLIT, 64'd0);
      1: write_reg(REG_ID_SPLIT, 64'd16);
      default: write_reg(REG_ID_SPLIT, 64'($urandom_range(16)));
    endcase
    case ($urandom_range(3))
      0: write_reg(REG_TABLE_BASE, '0);
      1: write_reg(REG_TABLE_BASE, '1);
      default: write_reg(REG_TABLE_BASE, rand64() & ~64'h7);
    endcase
  endtask

  task automatic test_random();
    int unsigned sidle[4], rstall[4], target;
    sidle = '{0, 81, 0, 38};
    rstall = '{0, 0, 81, 38};
    for (int p = 0; p < 4; p++) begin
      send_idle_pct = sidle[p];
      stall_pct = rstall[p];
      target = items_sent + RandItems / 4;
      while (items_sent < target) begin
        random_config();
        for (int k = 0; k < 15 && items_sent < target; k++) random_walk();
      end
    end
  endtask

  initial begin
    m_base = '0;
    m_xlate_en = 1'b0;
    m_irq_en = 1'b0;
    m_split = '0;
    m_phase = PH_IDLE;
    m_id = '0;
    m_addr = '0;
    m_access = '0;
    m_table = '0;
    m_mode = '0;
    m_level = '0;
    m_fault_valid = 1'b0;
    m_fault_code = FC_NONE;
    m_fault_id = '0;
    m_fault_addr = '0;
    m_irq = 1'b0;
    fails = 0;
    items_sent = 0;
    results_checked = 0;
    faults_seen = 0;
    cycles = 0;
    send_idle_pct = 0;
    stall_pct = 0;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    test_bypass();
    test_device_table();
    test_modes();
    test_pte_faults();
    test_random();
    drain();
    repeat (10) @(posedge clk_i);
    $display("sent %0d items, checked %0d results, %0d faulted walks",
             items_sent, results_checked, faults_seen);
    $display("all walk modes, device table levels and fault kinds under idle and stall mixes");
    if (fails == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/idtpw_pkg.sv
hw/rtl/idtpw_front.sv
hw/rtl/idtpw_walker.sv
hw/rtl/iommu_device_table_page_walker_unit.sv
tb/sv/tb.sv
